// ----- rtl/ldt_pkg.sv -----
// Shared types and constants for the LRU device table with publish gate.
// Used by the datapath, controller, top level and checker.
package ldt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int OCC_W       = 5;

  localparam logic [1:0] ST_REJECT = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_HIT    = 2'd2;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  localparam logic [OCC_W-1:0] CAP_RESET      = 5'd16;
  localparam logic [31:0]      INTERVAL_RESET = 32'd1000;

  typedef struct packed {
    logic [47:0]        device_address;
    logic signed [7:0]  signal_strength;
    logic [31:0]        time_now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              publish;
    logic [IDX_W-1:0]  slot;
    logic [31:0]       sighting_count;
    logic [31:0]       first_seen_time;
    logic              evicted;
    logic [47:0]       evicted_address;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [47:0] address;
    logic [7:0]  strength;
    logic [31:0] last_seen;
    logic [31:0] last_pub;
    logic [31:0] first_seen;
    logic [31:0] count;
  } entry_t;

  typedef struct packed {
    logic take_in;
    logic reject;
    logic scan;
    logic upd;
    logic evict;
    logic shift;
    logic append;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cap_zero;
    logic empty;
    logic hit;
    logic last;
    logic full;
    logic shift_more;
    logic out_busy;
  } dp_sts_t;

endpackage

// ----- rtl/lru_device_table_with_publish_gate_unit.sv -----
// LRU device table with per-device publish gate, top level.
// Depends on ldt_pkg, ldt_ctrl and ldt_dp.
//
// Input channel (in_valid/in_stall/in_data) carries one sighting per
// transaction: 48-bit address, signed strength, 32-bit ms time. Each
// transaction yields exactly one result on out_valid/out_stall/out_data.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 is capacity_in_use, index 1 is publish_interval.
// Items are handled one at a time. The table scan reads one entry per
// cycle and the eviction shifts one entry per cycle.
// A finished result sits in the output register; the next sighting is
// accepted while it waits. If out_stall holds, the following result
// waits in the datapath result register until the output register drains.
// Synchronous active-low reset empties the table and restores capacity
// 16 and interval 1000; table contents need no clearing.
module lru_device_table_with_publish_gate_unit import ldt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ldt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ldt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/ldt_dp.sv -----
// Datapath: entry table, config registers, scan/evict/shift/append logic,
// result and output registers. Depends on ldt_pkg; driven by ldt_ctrl.
module ldt_dp import ldt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             out_stall,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             out_valid,
  output out_item_t        out_data
);

  logic [OCC_W-1:0] cap_r;
  logic [31:0]      interval_r;
  logic [OCC_W-1:0] valid_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;

  entry_t           entries_r [MAX_ENTRIES];
  in_item_t         in_r;
  logic [31:0]      best_age_r;
  logic [IDX_W-1:0] oldest_r;
  logic [47:0]      oldest_addr_r;
  logic             ev_r;
  logic [47:0]      ev_addr_r;
  out_item_t        res_r;
  out_item_t        out_r;

  logic [OCC_W-1:0] cap_sat;
  logic [OCC_W-1:0] idx_p1;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_e;
  logic [31:0]      age;
  logic             due;
  logic [31:0]      cnt_inc;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  assign cap_sat = (cap_r > OCC_W'(MAX_ENTRIES)) ? OCC_W'(MAX_ENTRIES) : cap_r;
  assign idx_p1  = OCC_W'(idx_r) + OCC_W'(1);
  assign rd_idx  = cmd.shift ? idx_p1[IDX_W-1:0] : idx_r;
  assign rd_e    = entries_r[rd_idx];
  assign age     = in_r.time_now - rd_e.last_seen;
  assign due     = (in_r.time_now - rd_e.last_pub) >= interval_r;
  assign cnt_inc = rd_e.count + 32'd1;

  assign sts.cap_zero   = (cap_r == '0);
  assign sts.empty      = (valid_r == '0);
  assign sts.hit        = (rd_e.address == in_r.device_address);
  assign sts.last       = (idx_p1 == valid_r);
  assign sts.full       = (valid_r >= cap_sat);
  assign sts.shift_more = (idx_p1 < valid_r);
  assign sts.out_busy   = out_valid_r && out_stall;

  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = rd_e;
    if (cmd.upd) begin
      we = 1'b1;
      wd.last_seen = in_r.time_now;
      wd.strength  = in_r.signal_strength;
      wd.count     = cnt_inc;
      if (due) begin
        wd.last_pub = in_r.time_now;
      end
    end else if (cmd.shift && sts.shift_more) begin
      we = 1'b1;
    end else if (cmd.append) begin
      we = 1'b1;
      wa = valid_r[IDX_W-1:0];
      wd.address    = in_r.device_address;
      wd.strength   = in_r.signal_strength;
      wd.last_seen  = in_r.time_now;
      wd.last_pub   = in_r.time_now;
      wd.first_seen = in_r.time_now;
      wd.count      = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      interval_r  <= INTERVAL_RESET;
      valid_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAPACITY: cap_r      <= cfg_data[OCC_W-1:0];
          REG_INTERVAL: interval_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take_in) begin
        idx_r <= '0;
      end else if (cmd.scan && !sts.hit && !sts.last) begin
        idx_r <= idx_p1[IDX_W-1:0];
      end else if (cmd.evict) begin
        idx_r <= oldest_r;
      end else if (cmd.shift && sts.shift_more) begin
        idx_r <= idx_p1[IDX_W-1:0];
      end
      if (cmd.shift && !sts.shift_more) begin
        valid_r <= valid_r - OCC_W'(1);
      end else if (cmd.append) begin
        valid_r <= valid_r + OCC_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entries_r[wa] <= wd;
    end
    if (cmd.take_in) begin
      in_r      <= in_data;
      ev_r      <= 1'b0;
      ev_addr_r <= '0;
    end
    if (cmd.scan && !sts.hit && ((idx_r == '0) || (age > best_age_r))) begin
      best_age_r    <= age;
      oldest_r      <= idx_r;
      oldest_addr_r <= rd_e.address;
    end
    if (cmd.evict) begin
      ev_r      <= 1'b1;
      ev_addr_r <= oldest_addr_r;
    end
    if (cmd.reject) begin
      res_r <= '{status: ST_REJECT, publish: 1'b0, slot: '0, sighting_count: '0,
                 first_seen_time: '0, evicted: 1'b0, evicted_address: '0,
                 occupancy: valid_r};
    end else if (cmd.upd) begin
      res_r <= '{status: ST_HIT, publish: due, slot: idx_r, sighting_count: cnt_inc,
                 first_seen_time: rd_e.first_seen, evicted: 1'b0, evicted_address: '0,
                 occupancy: valid_r};
    end else if (cmd.append) begin
      res_r <= '{status: ST_NEW, publish: 1'b1, slot: valid_r[IDX_W-1:0],
                 sighting_count: 32'd1, first_seen_time: in_r.time_now, evicted: ev_r,
                 evicted_address: ev_addr_r, occupancy: valid_r + OCC_W'(1)};
    end
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/ldt_ctrl.sv -----
// Controller FSM: sequences accept, scan, update, evict/shift, append and
// output load. Depends on ldt_pkg; commands ldt_dp.
module ldt_ctrl import ldt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_UPD    = 8'b0000_1000,
    S_EVICT  = 8'b0001_0000,
    S_SHIFT  = 8'b0010_0000,
    S_APPEND = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.cap_zero) begin
          cmd.reject = 1'b1;
          state_nxt  = S_DONE;
        end else if (sts.empty) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = S_UPD;
        end else if (sts.last) begin
          state_nxt = sts.full ? S_EVICT : S_APPEND;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.shift_more) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/ldt_checker.sv -----
// Port-level assertions for the LRU device table, bound to the top level.
// Depends on ldt_pkg.
module ldt_checker import ldt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_REJECT || out_data.status == ST_NEW ||
                   out_data.status == ST_HIT) &&
                  (out_data.occupancy <= OCC_W'(MAX_ENTRIES)))
    else $error("bad status or occupancy");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_REJECT |->
      !out_data.publish && !out_data.evicted && out_data.sighting_count == '0)
    else $error("rejected result not cleared");

  a_evict_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.status == ST_NEW && out_data.publish)
    else $error("eviction without new entry");

endmodule

bind lru_device_table_with_publish_gate_unit ldt_checker u_ldt_checker (.*);
